>>> sv/lcm_pkg.sv
// Shared types, constants and helpers for the LED cube layer multiplexer.
// No dependencies; imported by lcm_store and led_cube_layer_multiplexer_top.
package lcm_pkg;

   localparam int LAYERS     = 8;
   localparam int BYTE_W     = 8;
   localparam int ROW_W      = LAYERS * BYTE_W;
   localparam int LAYER_W    = 3;
   localparam int FUNC_W     = 2;
   localparam int INDEX_W    = 6;
   localparam int PRESCALE_W = 8;
   localparam int FRAME_W    = 8;
   localparam int SHOWN_W    = 7;
   localparam int COUNT_W    = 32;
   localparam int PADDR_W    = 3;
   localparam int PDATA_W    = 32;

   // word index of the prescale register on the configuration port
   localparam logic CSR_PRESCALE = 1'b0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_FILL  = 2'd1,
      FUNC_TICK  = 2'd2
   } func_type;

   typedef logic [LAYER_W-1:0] layer_type;

   typedef struct packed {
      logic                 wr_en;
      logic                 fill_en;
      logic [LAYER_W-1:0]   row;
      logic [LAYER_W-1:0]   col;
      logic [BYTE_W-1:0]    data;
   } store_cmd_type;

   // reverse the order of the four bit pairs into the latch wiring order
   function automatic logic [BYTE_W-1:0] permute_byte(input logic [BYTE_W-1:0] b);
      permute_byte = {b[1], b[0], b[3], b[2], b[5], b[4], b[7], b[6]};
   endfunction

endpackage

>>> sv/lcm_store.sv
// Frame store: eight layer rows of eight latch bytes, byte write, whole fill, row read.
// Depends on lcm_pkg. Rows never written since reset read as all ones.
module lcm_store (
   input  logic                         clock,
   input  logic                         reset,
   input  lcm_pkg::store_cmd_type       cmd,
   input  lcm_pkg::layer_type           rd_row,
   output logic [lcm_pkg::ROW_W-1:0]    rd_data
);
   import lcm_pkg::*;

   logic [ROW_W-1:0]  rows_ff [LAYERS];
   logic [LAYERS-1:0] valid_ff;
   logic [LAYERS-1:0] valid_in;
   logic [ROW_W-1:0]  wr_row_in;

   always_comb begin
      wr_row_in = valid_ff[cmd.row] ? rows_ff[cmd.row] : {ROW_W{1'b1}};
      wr_row_in[{cmd.col, 3'b000} +: BYTE_W] = cmd.data;
      rd_data = valid_ff[rd_row] ? rows_ff[rd_row] : {ROW_W{1'b1}};
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.fill_en) begin
         valid_in = {LAYERS{1'b1}};
      end else if (cmd.wr_en) begin
         valid_in[cmd.row] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fill_en) begin
         for (int r = 0; r < LAYERS; r++) begin
            rows_ff[r] <= {LAYERS{cmd.data}};
         end
      end else if (cmd.wr_en) begin
         rows_ff[cmd.row] <= wr_row_in;
      end
   end

endmodule

>>> sv/led_cube_layer_multiplexer_top.sv
// Top level of the LED cube layer multiplexer: item stage, refresh control, CSR port.
// Depends on lcm_pkg and lcm_store.
//
// Usage:
//  - Items enter on start with req_func, req_pixel_index and req_data_byte. busy
//    is always low, so an item is taken at every edge where start is high.
//  - A write item stores one permuted, inverted image byte; a fill item stores the
//    inverted byte everywhere; a tick item advances the prescaler and, when it
//    fires, shows the current layer.
//  - A firing tick produces one item on the result ports, marked by rsp_strobe for
//    a single cycle; writes, fills and non-firing ticks produce nothing.
//  - A tick is captured in the item register and its result in the result register,
//    which drives the ports. Throughput: one item per cycle, set by the single combinational
//    pass between the item register and the result register.
//  - Results cannot be stalled: the receiver must take rsp_strobe as it comes.
//  - tick_prescale sits at byte address 0 of the APB port; write it only while
//    no item is in flight.
//  - Reset clears all counters, the prescale register and the layer pointer, and
//    the frame store reads as all ones (every LED off) until written.
module led_cube_layer_multiplexer_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [lcm_pkg::FUNC_W-1:0]         req_func,
   input  logic [lcm_pkg::INDEX_W-1:0]        req_pixel_index,
   input  logic [lcm_pkg::BYTE_W-1:0]         req_data_byte,
   output logic                               rsp_strobe,
   output logic [lcm_pkg::LAYERS-1:0]         rsp_layer_select,
   output logic [lcm_pkg::ROW_W-1:0]          rsp_latch_bytes,
   output logic [lcm_pkg::SHOWN_W-1:0]        rsp_frames_shown,
   output logic [lcm_pkg::COUNT_W-1:0]        rsp_refresh_count,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [lcm_pkg::PADDR_W-1:0]        paddr,
   input  logic [lcm_pkg::PDATA_W-1:0]        pwdata,
   output logic [lcm_pkg::PDATA_W-1:0]        prdata,
   output logic                               pready
);
   import lcm_pkg::*;

   // item register
   logic                    req_valid_ff;
   logic [FUNC_W-1:0]       func_ff;
   logic [INDEX_W-1:0]      index_ff;
   logic [BYTE_W-1:0]       data_ff;

   // refresh state
   layer_type               layer_ff, layer_in;
   logic                    changed_ff, changed_in;
   logic [FRAME_W-1:0]      frame_ff, frame_in;
   logic [PRESCALE_W-1:0]   prescale_ff, prescale_in;
   logic [COUNT_W-1:0]      refresh_ff, refresh_in;
   logic [PRESCALE_W-1:0]   tick_prescale_ff;

   // result register
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic [LAYERS-1:0]       rsp_select_ff;
   logic [ROW_W-1:0]        rsp_bytes_ff;
   logic [SHOWN_W-1:0]      rsp_shown_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;

   store_cmd_type           store_cmd;
   layer_type               layer_show;
   logic [ROW_W-1:0]        row_data;
   logic                    csr_write;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_PRESCALE) begin
         prdata = {{(PDATA_W-PRESCALE_W){1'b0}}, tick_prescale_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_prescale_ff <= '0;
      end else if (csr_write && paddr[2] == CSR_PRESCALE) begin
         tick_prescale_ff <= pwdata[PRESCALE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         func_ff  <= req_func;
         index_ff <= req_pixel_index;
         data_ff  <= req_data_byte;
      end
   end

   // a changed image restarts the scan at layer 0
   assign layer_show = changed_ff ? '0 : layer_ff;

   lcm_store u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (store_cmd),
      .rd_row  (layer_show),
      .rd_data (row_data)
   );

   always_comb begin
      layer_in      = layer_ff;
      changed_in    = changed_ff;
      frame_in      = frame_ff;
      prescale_in   = prescale_ff;
      refresh_in    = refresh_ff;
      rsp_strobe_in = 1'b0;

      store_cmd.wr_en   = 1'b0;
      store_cmd.fill_en = 1'b0;
      store_cmd.row     = index_ff[LAYER_W-1:0];
      store_cmd.col     = ~index_ff[INDEX_W-1:LAYER_W];
      store_cmd.data    = ~permute_byte(data_ff);

      if (req_valid_ff) begin
         case (func_ff)
            FUNC_WRITE: begin
               store_cmd.wr_en = 1'b1;
               changed_in      = 1'b1;
               frame_in        = '0;
               prescale_in     = '0;
            end
            FUNC_FILL: begin
               store_cmd.fill_en = 1'b1;
               store_cmd.data    = ~data_ff;
               changed_in        = 1'b1;
               frame_in          = '0;
               prescale_in       = '0;
            end
            FUNC_TICK: begin
               if (prescale_ff < tick_prescale_ff) begin
                  prescale_in = prescale_ff + 1'b1;
               end else begin
                  prescale_in   = '0;
                  changed_in    = 1'b0;
                  refresh_in    = refresh_ff + 1'b1;
                  rsp_strobe_in = 1'b1;
                  layer_in      = layer_show + 1'b1;
                  if (layer_show == layer_type'(LAYERS-1)) begin
                     frame_in = frame_ff + 1'b1;
                  end
               end
            end
            default: begin
               // unused selector: drop the item
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_ff      <= '0;
         changed_ff    <= 1'b0;
         frame_ff      <= '0;
         prescale_ff   <= '0;
         refresh_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         layer_ff      <= layer_in;
         changed_ff    <= changed_in;
         frame_ff      <= frame_in;
         prescale_ff   <= prescale_in;
         refresh_ff    <= refresh_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_strobe_in) begin
         rsp_select_ff <= LAYERS'(1) << layer_show;
         rsp_bytes_ff  <= row_data;
         rsp_shown_ff  <= frame_ff[FRAME_W-1:1];
         rsp_count_ff  <= refresh_in;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_layer_select  = rsp_select_ff;
   assign rsp_latch_bytes   = rsp_bytes_ff;
   assign rsp_frames_shown  = rsp_shown_ff;
   assign rsp_refresh_count = rsp_count_ff;

endmodule
